// File: src/prp_pkg.sv
package prp_pkg;

	localparam int PAGE_ENTRIES_DEF  = 64;
	localparam int FRAME_ENTRIES_DEF = 64;
	localparam int CLOCK_SLOTS_DEF   = 16;

	localparam int TIME_W = 32;
	localparam int CFG_W  = 7;
	localparam int PG_W   = 6;
	localparam int FR_W   = 6;

	// operations
	localparam logic [1:0] FUNC_READ    = 2'd0;
	localparam logic [1:0] FUNC_WRITE   = 2'd1;
	localparam logic [1:0] FUNC_RELEASE = 2'd2;

	// replacement policies
	localparam logic [1:0] POL_FIFO  = 2'd0;
	localparam logic [1:0] POL_LRU   = 2'd1;
	localparam logic [1:0] POL_CLOCK = 2'd2;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_NOFRAME = 2'd2;

	// register indexes
	localparam logic [1:0] REG_POLICY    = 2'd0;
	localparam logic [1:0] REG_MAX_FRAME = 2'd1;
	localparam logic [1:0] REG_FRAME_CNT = 2'd2;
	localparam logic [1:0] REG_PAGE_CNT  = 2'd3;

	localparam logic [7:0] RESET_MAX_FRAME = 8'd4;
	localparam logic [7:0] RESET_FRAME_CNT = 8'd64;
	localparam logic [7:0] RESET_PAGE_CNT  = 8'd64;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_HIT   = 11'b00000000010,
		S_SCAN  = 11'b00000000100,
		S_FREE  = 11'b00000001000,
		S_PICK  = 11'b00000010000,
		S_PMOD  = 11'b00000100000,
		S_CLOCK = 11'b00001000000,
		S_SLOT  = 11'b00010000000,
		S_VIC   = 11'b00100000000,
		S_LOAD  = 11'b01000000000,
		S_SPARE = 11'b10000000000
	} state_t;

endpackage

// File: src/prp_ram.sv
module prp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/page_replacement_unit_top.sv
// page replacement unit: page table and frame map of one process
//
// command channel: func and page are taken at a clock edge with start high
// and busy low. busy stays high while the item is worked on. one result per
// item shows on hit, frame, victim_valid, victim_page, writeback and status
// for exactly one cycle with done high; the receiver cannot stall.
// configuration: cfg_we writes cfg_data to cfg_idx (0 policy, 1 frame quota,
// 2 frame count, 3 page count); the user writes only while idle, unenforced.
// release, out-of-range and unknown ops are done from idle; a hit goes
// through S_HIT. a miss scans the page table, then the frame map and the
// ring, or for the clock policy up to 4 ring passes plus the pointer
// reduction, and then loads. the page table scan goes through the time
// memories and the ring walk takes one slot per cycle; one item at a time.
// reset: table empty, all frames free, ring empty, pointer and access
// counter zero, policy fifo, quota 4, 64 frames, 64 pages.
module page_replacement_unit_top #(
	parameter int PAGE_ENTRIES  = prp_pkg::PAGE_ENTRIES_DEF,
	parameter int FRAME_ENTRIES = prp_pkg::FRAME_ENTRIES_DEF,
	parameter int CLOCK_SLOTS   = prp_pkg::CLOCK_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic [prp_pkg::PG_W-1:0]  page,
	output logic                      done,
	output logic                      hit,
	output logic [prp_pkg::FR_W-1:0]  frame,
	output logic                      victim_valid,
	output logic [prp_pkg::PG_W-1:0]  victim_page,
	output logic                      writeback,
	output logic [1:0]                status,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [prp_pkg::CFG_W-1:0] cfg_data
);

	import prp_pkg::*;

	localparam int PW  = $clog2(PAGE_ENTRIES);
	localparam int FW  = $clog2(FRAME_ENTRIES);
	localparam int SW  = (CLOCK_SLOTS > 1) ? $clog2(CLOCK_SLOTS) : 1;
	localparam int PCW = $clog2(PAGE_ENTRIES + 1);
	localparam int FCW = $clog2(FRAME_ENTRIES + 1);
	localparam int QW  = $clog2(CLOCK_SLOTS + 1);
	localparam int IW  = (PCW > FCW) ? PCW : FCW;
	localparam int SLW = PW + 1;
	localparam logic [SLW-1:0] SLOT_EMPTY = '1;

	// configuration
	logic [1:0] policy_q;
	logic [4:0] maxf_q;
	logic [6:0] fcnt_q;
	logic [6:0] pcnt_q;

	// table flags and free map
	logic [PAGE_ENTRIES-1:0]  present_q;
	logic [PAGE_ENTRIES-1:0]  modified_q;
	logic [PAGE_ENTRIES-1:0]  referenced_q;
	logic [FRAME_ENTRIES-1:0] fbusy_q;
	logic [SLW-1:0]           slot_q [CLOCK_SLOTS];
	logic [SW-1:0]            ptr_q;
	logic [TIME_W-1:0]        counter_q;

	// sequencer
	state_t            state_q;
	logic [PW-1:0]     pg_q;
	logic              wr_q;
	logic [IW-1:0]     idx_q;
	logic [PCW-1:0]    used_q;
	logic [PW-1:0]     best_q;
	logic [TIME_W-1:0] best_t_q;
	logic              best_v_q;
	logic [PW-1:0]     victim_q;
	logic [SW-1:0]     vslot_q;
	logic              vslot_v_q;
	logic [FW-1:0]     fr_q;
	logic              evict_q;
	logic              fill_q;
	logic [QW-1:0]     sc_q;
	logic [QW-1:0]     step_q;
	logic [1:0]        round_q;
	logic              scan_v_s1;
	logic [PW-1:0]     scan_idx_s1;

	logic [PCW-1:0]    pc_eff;
	logic [QW-1:0]     q_eff;
	logic [FCW-1:0]    fc_eff;
	logic [SLW-1:0]    cur_slot;
	logic [PW-1:0]     cur_pg;
	logic              cur_live;
	logic [QW-1:0]     sc_next;
	logic [TIME_W-1:0] load_rd;
	logic [TIME_W-1:0] use_rd;
	logic [TIME_W-1:0] t_rd;
	logic [FW-1:0]     frame_rd;
	logic [FW-1:0]     fr_sel;
	logic [PW-1:0]     frame_raddr;
	logic              use_we;
	logic              load_we;

	// effective sizes after clamping
	always_comb begin
		pc_eff = (32'(pcnt_q) > PAGE_ENTRIES) ? PCW'(PAGE_ENTRIES) : PCW'(pcnt_q);
		q_eff  = (32'(maxf_q) > CLOCK_SLOTS) ? QW'(CLOCK_SLOTS) : QW'(maxf_q);
		fc_eff = (32'(fcnt_q) > FRAME_ENTRIES) ? FCW'(FRAME_ENTRIES) : FCW'(fcnt_q);
	end

	// ring slot under the walker, live when it holds a present page in range
	always_comb begin
		cur_slot = slot_q[sc_q[SW-1:0]];
		cur_pg   = cur_slot[PW-1:0];
		cur_live = (32'(cur_slot) < 32'(pc_eff)) && present_q[cur_pg];
		sc_next  = (32'(sc_q) + 1 == 32'(q_eff)) ? '0 : sc_q + QW'(1);
	end

	assign t_rd        = (policy_q == POL_LRU) ? use_rd : load_rd;
	assign fr_sel      = evict_q ? frame_rd : fr_q;
	assign frame_raddr = (state_q == S_VIC) ? victim_q : PW'(page);
	assign use_we      = (state_q == S_HIT) || (state_q == S_LOAD);
	assign load_we     = (state_q == S_LOAD);
	assign busy        = (state_q != S_IDLE);

	prp_ram #(.WIDTH(TIME_W), .DEPTH(PAGE_ENTRIES)) u_load_time (
		.clk   (clk),
		.we    (load_we),
		.waddr (pg_q),
		.wdata (counter_q),
		.raddr (idx_q[PW-1:0]),
		.rdata (load_rd)
	);

	prp_ram #(.WIDTH(TIME_W), .DEPTH(PAGE_ENTRIES)) u_use_time (
		.clk   (clk),
		.we    (use_we),
		.waddr (pg_q),
		.wdata (counter_q),
		.raddr (idx_q[PW-1:0]),
		.rdata (use_rd)
	);

	prp_ram #(.WIDTH(FW), .DEPTH(PAGE_ENTRIES)) u_page_frame (
		.clk   (clk),
		.we    (load_we),
		.waddr (pg_q),
		.wdata (fr_sel),
		.raddr (frame_raddr),
		.rdata (frame_rd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			maxf_q   <= RESET_MAX_FRAME[4:0];
			fcnt_q   <= RESET_FRAME_CNT[6:0];
			pcnt_q   <= RESET_PAGE_CNT[6:0];
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POLICY:    policy_q <= cfg_data[1:0];
				REG_MAX_FRAME: maxf_q   <= cfg_data[4:0];
				REG_FRAME_CNT: fcnt_q   <= cfg_data;
				REG_PAGE_CNT:  pcnt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pg_q      <= PW'(page);
				wr_q      <= (func == FUNC_WRITE);
				idx_q     <= '0;
				used_q    <= '0;
				best_v_q  <= 1'b0;
				evict_q   <= 1'b0;
				vslot_v_q <= 1'b0;
			end
			S_SCAN: begin
				if (32'(idx_q) < 32'(pc_eff)) begin
					idx_q <= idx_q + IW'(1);
				end
				if (scan_v_s1 && present_q[scan_idx_s1]) begin
					used_q <= used_q + PCW'(1);
					if (!best_v_q || t_rd < best_t_q) begin
						best_v_q <= 1'b1;
						best_q   <= scan_idx_s1;
						best_t_q <= t_rd;
					end
				end
				if (32'(idx_q) >= 32'(pc_eff) && !scan_v_s1) begin
					idx_q <= '0;
				end
			end
			S_FREE: begin
				if (32'(idx_q) < 32'(fc_eff)) begin
					if (!fbusy_q[idx_q[FW-1:0]]) begin
						fr_q   <= idx_q[FW-1:0];
						fill_q <= 1'b1;
						sc_q   <= '0;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
			end
			S_PICK: begin
				victim_q <= best_q;
				fill_q   <= 1'b0;
				sc_q     <= (policy_q == POL_CLOCK) ? QW'(ptr_q) : '0;
			end
			S_PMOD: begin
				if (32'(sc_q) >= 32'(q_eff)) begin
					sc_q <= sc_q - q_eff;
				end else begin
					step_q  <= '0;
					round_q <= '0;
				end
			end
			S_CLOCK: begin
				if (cur_live && !referenced_q[cur_pg] && modified_q[cur_pg] == round_q[0]) begin
					victim_q  <= cur_pg;
					vslot_q   <= sc_q[SW-1:0];
					vslot_v_q <= 1'b1;
				end else begin
					sc_q <= sc_next;
					if (32'(step_q) + 1 == 32'(q_eff)) begin
						step_q  <= '0;
						round_q <= round_q + 2'd1;
					end else begin
						step_q <= step_q + QW'(1);
					end
				end
			end
			S_SLOT: begin
				if (32'(sc_q) < 32'(q_eff)) begin
					if (!fill_q && cur_slot == SLW'(victim_q)) begin
						vslot_q   <= sc_q[SW-1:0];
						vslot_v_q <= 1'b1;
					end
					sc_q <= sc_q + QW'(1);
				end
			end
			S_VIC: begin
				evict_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// control state, table flags, ring and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			present_q    <= '0;
			modified_q   <= '0;
			referenced_q <= '0;
			fbusy_q      <= '0;
			for (int i = 0; i < CLOCK_SLOTS; i++) begin
				slot_q[i] <= SLOT_EMPTY;
			end
			ptr_q        <= '0;
			counter_q    <= '0;
			scan_v_s1    <= 1'b0;
			scan_idx_s1  <= '0;
			done         <= 1'b0;
			hit          <= 1'b0;
			frame        <= '0;
			victim_valid <= 1'b0;
			victim_page  <= '0;
			writeback    <= 1'b0;
			status       <= ST_OK;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						hit          <= 1'b0;
						frame        <= '0;
						victim_valid <= 1'b0;
						victim_page  <= '0;
						writeback    <= 1'b0;
						status       <= ST_OK;
						if (func == FUNC_RELEASE) begin
							// every busy frame belongs to a present page
							present_q    <= '0;
							modified_q   <= '0;
							referenced_q <= '0;
							fbusy_q      <= '0;
							for (int i = 0; i < CLOCK_SLOTS; i++) begin
								slot_q[i] <= SLOT_EMPTY;
							end
							ptr_q <= '0;
							done  <= 1'b1;
						end else if (func != FUNC_READ && func != FUNC_WRITE) begin
							done <= 1'b1;
						end else if (32'(page) >= 32'(pc_eff)) begin
							status <= ST_RANGE;
							done   <= 1'b1;
						end else if (present_q[PW'(page)]) begin
							state_q <= S_HIT;
						end else begin
							scan_v_s1 <= 1'b0;
							state_q   <= S_SCAN;
						end
					end
				end
				S_HIT: begin
					referenced_q[pg_q] <= 1'b1;
					if (wr_q) begin
						modified_q[pg_q] <= 1'b1;
					end
					counter_q <= counter_q + 32'd1;
					hit       <= 1'b1;
					frame     <= FR_W'(frame_rd);
					done      <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_SCAN: begin
					// one table entry a cycle through the time memories
					if (32'(idx_q) < 32'(pc_eff)) begin
						scan_v_s1   <= 1'b1;
						scan_idx_s1 <= idx_q[PW-1:0];
					end else begin
						scan_v_s1 <= 1'b0;
					end
					if (32'(idx_q) >= 32'(pc_eff) && !scan_v_s1) begin
						state_q <= (32'(used_q) < 32'(q_eff)) ? S_FREE : S_PICK;
					end
				end
				S_FREE: begin
					// lowest free frame
					if (32'(idx_q) < 32'(fc_eff)) begin
						if (!fbusy_q[idx_q[FW-1:0]]) begin
							fbusy_q[idx_q[FW-1:0]] <= 1'b1;
							state_q <= S_SLOT;
						end
					end else begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (policy_q == POL_CLOCK) begin
						if (q_eff == '0) begin
							status  <= ST_NOFRAME;
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_PMOD;
						end
					end else if (best_v_q) begin
						state_q <= S_SLOT;
					end else begin
						status  <= ST_NOFRAME;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_PMOD: begin
					// pointer modulo ring size by repeated subtraction
					if (32'(sc_q) < 32'(q_eff)) begin
						state_q <= S_CLOCK;
					end
				end
				S_CLOCK: begin
					// passes alternate: clean unreferenced, then dirty with ref clearing
					if (cur_live && !referenced_q[cur_pg] && modified_q[cur_pg] == round_q[0]) begin
						state_q <= S_VIC;
					end else begin
						if (cur_live && round_q[0]) begin
							referenced_q[cur_pg] <= 1'b0;
						end
						if (32'(step_q) + 1 == 32'(q_eff) && round_q == 2'd3) begin
							status  <= ST_NOFRAME;
							done    <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_SLOT: begin
					// fill mode: first dead slot takes the page; else find the victim's slot
					if (32'(sc_q) >= 32'(q_eff)) begin
						state_q <= fill_q ? S_LOAD : S_VIC;
					end else if (fill_q && !cur_live) begin
						slot_q[sc_q[SW-1:0]] <= SLW'(pg_q);
						state_q <= S_LOAD;
					end else if (!fill_q && cur_slot == SLW'(victim_q)) begin
						state_q <= S_VIC;
					end
				end
				S_VIC: begin
					// frame memory read of the victim is under way
					if (vslot_v_q) begin
						slot_q[vslot_q] <= SLW'(pg_q);
						if (policy_q == POL_CLOCK) begin
							ptr_q <= (32'(vslot_q) + 1 == 32'(q_eff)) ? '0 : vslot_q + SW'(1);
						end
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (evict_q) begin
						present_q[victim_q]    <= 1'b0;
						modified_q[victim_q]   <= 1'b0;
						referenced_q[victim_q] <= 1'b0;
						victim_valid <= 1'b1;
						victim_page  <= PG_W'(victim_q);
						writeback    <= modified_q[victim_q];
					end
					present_q[pg_q]    <= 1'b1;
					referenced_q[pg_q] <= 1'b1;
					modified_q[pg_q]   <= wr_q;
					counter_q <= counter_q + 32'd1;
					frame     <= FR_W'(fr_sel);
					done      <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
